@@ rtl/bmid_pkg.sv @@
`default_nettype none
package bmid_pkg;

    localparam int ID_WIDTH_DEF = 16;

    localparam int TIME_W  = 32;
    localparam int BDUR_W  = 20;
    localparam int PBITS_W = 5;
    localparam int SYNCQ_W = 6;
    localparam int LIM_W   = 29;
    localparam int S4_W    = TIME_W + 2;

    localparam int IN_TDATA_W = ((TIME_W + 3 + 7) / 8) * 8;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [BDUR_W-1:0]  BDUR_RST  = BDUR_W'(33333);
    localparam logic [PBITS_W-1:0] PBITS_RST = PBITS_W'(8);
    localparam logic [SYNCQ_W-1:0] SYNCQ_RST = SYNCQ_W'(8);

    typedef logic [LIM_W-1:0] lim_t;

    typedef enum logic [1:0] {
        REG_BIT_DUR = 2'd0,
        REG_PAYLOAD = 2'd1,
        REG_SYNC_Q  = 2'd2
    } cfg_reg_t;

    localparam logic [1:0] CAND_NEED_REPLACE = 2'd3;
    localparam logic [1:0] CAND_NEED_NORMAL  = 2'd2;
    localparam logic [1:0] CAND_MAX          = 2'd3;

    // elapsed time, clamped at zero
    function automatic logic [TIME_W-1:0] since(input logic [TIME_W-1:0] now,
                                                input logic [TIME_W-1:0] then_t);
        since = (now <= then_t) ? '0 : now - then_t;
    endfunction

    // elapsed time in quarter microseconds
    function automatic logic [S4_W-1:0] since4(input logic [TIME_W-1:0] now,
                                               input logic [TIME_W-1:0] then_t);
        since4 = {since(now, then_t), 2'b00};
    endfunction

endpackage
`default_nettype wire

@@ rtl/blink_marker_id_decoder.sv @@
`default_nettype none
// Channel   Dir  Ports      Fields (low bit up)
// s_axis    in   tdata      time_us[31:0], matched, bright, ignore_decode, zero fill
//                tuser      req_type
// m_axis    out  tdata      retired, seen_now, id_ok, marker_id, report_marker,
//                           unseen_age_us, zero fill
// apb       in   p*         0x0 bit_duration_us, 0x4 payload_bits, 0x8 sync_quarter_bits
//
// One beat per cycle while m_axis_tready holds.
// The whole decode step sits between the input register and the result register.
// Bit-time limits are registered products of the config registers, except the sample point.
// While a result waits on m_axis_tready the input register takes one more beat,
// then s_axis_tready drops.
// aresetn is synchronous, active low; it clears the track and restores config defaults.
module blink_marker_id_decoder #(
    parameter int ID_WIDTH = bmid_pkg::ID_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // time_us[31:0], matched[32], bright[33], ignore_decode[34]
    input  wire logic [bmid_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // req_type[0]
    input  wire logic [0:0]                           s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // retired, seen_now, id_ok, marker_id, report_marker, unseen_age_us
    output logic [((ID_WIDTH + 36 + 7) / 8) * 8-1:0]  m_axis_tdata,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [bmid_pkg::APB_AW-1:0]          paddr,
    input  wire logic [bmid_pkg::APB_DW-1:0]          pwdata,
    output logic [bmid_pkg::APB_DW-1:0]               prdata,
    output logic                                      pready
);
    import bmid_pkg::*;

    localparam int OUT_W = ((ID_WIDTH + 36 + 7) / 8) * 8;
    localparam int OUT_USED = ID_WIDTH + 36;

    // config
    logic [BDUR_W-1:0]  bdur_reg;
    logic [PBITS_W-1:0] pbits_reg;
    logic [SYNCQ_W-1:0] syncq_reg;
    cfg_reg_t           cfg_sel;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bdur_reg  <= BDUR_RST;
            pbits_reg <= PBITS_RST;
            syncq_reg <= SYNCQ_RST;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_BIT_DUR: bdur_reg  <= pwdata[BDUR_W-1:0];
                REG_PAYLOAD: pbits_reg <= pwdata[PBITS_W-1:0];
                REG_SYNC_Q:  syncq_reg <= pwdata[SYNCQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_BIT_DUR: prdata = APB_DW'(bdur_reg);
            REG_PAYLOAD: prdata = APB_DW'(pbits_reg);
            REG_SYNC_Q:  prdata = APB_DW'(syncq_reg);
            default:     prdata = '0;
        endcase
    end

    // limits in quarter microseconds
    lim_t unseen_lim_reg, static_lim_reg, stale_lim_reg, sync_lim_reg;
    lim_t nine_bd_reg;

    always_ff @(posedge aclk) begin
        unseen_lim_reg <= lim_t'(bdur_reg) * lim_t'({(PBITS_W'(pbits_reg) + 6'd2), 2'b00});
        static_lim_reg <= lim_t'(bdur_reg) * lim_t'({(6'(pbits_reg) + 6'd10), 2'b00});
        stale_lim_reg  <= lim_t'(bdur_reg) * lim_t'(9'(6'(pbits_reg) + 6'd6) * 9'd10);
        sync_lim_reg   <= lim_t'(bdur_reg) * lim_t'(syncq_reg);
        nine_bd_reg    <= lim_t'(bdur_reg) * lim_t'(4'd9);
    end

    // input register
    logic              in_vld_reg;
    logic              in_req_obs_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic              in_matched_reg, in_bright_reg, in_ignore_reg;
    logic              out_vld_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              advance;
    logic              in_take;

    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_take) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_req_obs_reg <= s_axis_tuser[0];
            in_time_reg    <= s_axis_tdata[TIME_W-1:0];
            in_matched_reg <= s_axis_tdata[TIME_W];
            in_bright_reg  <= s_axis_tdata[TIME_W+1];
            in_ignore_reg  <= s_axis_tdata[TIME_W+2];
        end
    end

    // track state
    logic                track_active_reg, track_active_next;
    logic                decoding_reg, decoding_next;
    logic [TIME_W-1:0]   sync_stamp_reg, sync_stamp_next;
    logic [PBITS_W-1:0]  bit_count_reg, bit_count_next;
    logic [ID_WIDTH-1:0] shift_id_reg, shift_id_next;
    logic                prev_bright_reg, prev_bright_next;
    logic                hs_vld_reg, hs_vld_next;
    logic [TIME_W-1:0]   hs_reg, hs_next;
    logic                ls_vld_reg, ls_vld_next;
    logic [TIME_W-1:0]   ls_reg, ls_next;
    logic                sync_armed_reg, sync_armed_next;
    logic                conf_vld_reg, conf_vld_next;
    logic [ID_WIDTH-1:0] conf_id_reg, conf_id_next;
    logic [ID_WIDTH-1:0] cand_id_reg, cand_id_next;
    logic [1:0]          cand_cnt_reg, cand_cnt_next;
    logic [TIME_W-1:0]   cand_stamp_reg, cand_stamp_next;
    logic [TIME_W-1:0]   last_seen_reg, last_seen_next;
    logic                visible_reg, visible_next;

    logic                cur, retired, live_item;
    logic [S4_W-1:0]     age_pre4, el4;
    logic [ID_WIDTH:0]   shift_ext;
    logic [ID_WIDTH-1:0] shift_new;
    logic [PBITS_W-1:0]  bc_new;
    logic                stale, arm_now;
    logic [1:0]          cnt_tmp, need;
    logic [TIME_W-1:0]   t;
    lim_t                samp_lim;

    assign t         = in_time_reg;
    assign age_pre4  = since4(t, last_seen_reg);
    assign el4       = since4(t, sync_stamp_reg);
    // next sample point: (6 + 4 * bit_count) quarter bits after sync
    assign samp_lim  = lim_t'(bdur_reg) * lim_t'(8'({bit_count_reg, 2'b00}) + 8'd6);
    assign shift_ext = {shift_id_reg, cur};
    assign shift_new = shift_ext[ID_WIDTH-1:0];
    assign bc_new    = bit_count_reg + PBITS_W'(1);
    assign stale     = since4(t, cand_stamp_reg) > S4_W'(stale_lim_reg);
    assign arm_now   = hs_vld_reg && (since4(t, hs_reg) >= S4_W'(sync_lim_reg));
    assign need      = (shift_new != '0 && conf_vld_reg && conf_id_reg == '0) ?
                       CAND_NEED_REPLACE : CAND_NEED_NORMAL;
    assign live_item = !in_req_obs_reg || track_active_reg;

    always_comb begin
        track_active_next = track_active_reg;
        decoding_next     = decoding_reg;
        sync_stamp_next   = sync_stamp_reg;
        bit_count_next    = bit_count_reg;
        shift_id_next     = shift_id_reg;
        prev_bright_next  = prev_bright_reg;
        hs_vld_next       = hs_vld_reg;
        hs_next           = hs_reg;
        ls_vld_next       = ls_vld_reg;
        ls_next           = ls_reg;
        sync_armed_next   = sync_armed_reg;
        conf_vld_next     = conf_vld_reg;
        conf_id_next      = conf_id_reg;
        cand_id_next      = cand_id_reg;
        cand_cnt_next     = cand_cnt_reg;
        cand_stamp_next   = cand_stamp_reg;
        last_seen_next    = last_seen_reg;
        visible_next      = visible_reg;
        cur               = 1'b0;
        retired           = 1'b0;
        cnt_tmp           = cand_cnt_reg;

        if (!in_req_obs_reg) begin
            track_active_next = 1'b1;
            decoding_next     = 1'b0;
            sync_stamp_next   = '0;
            bit_count_next    = '0;
            shift_id_next     = '0;
            prev_bright_next  = in_bright_reg;
            hs_vld_next       = in_bright_reg;
            hs_next           = t;
            ls_vld_next       = !in_bright_reg;
            ls_next           = t;
            sync_armed_next   = 1'b0;
            conf_vld_next     = 1'b0;
            conf_id_next      = '0;
            cand_id_next      = '0;
            cand_cnt_next     = '0;
            cand_stamp_next   = '0;
            last_seen_next    = t;
            visible_next      = 1'b1;
        end else if (track_active_reg) begin
            if (age_pre4 >= S4_W'(unseen_lim_reg)) begin
                track_active_next = 1'b0;
                visible_next      = 1'b0;
                retired           = 1'b1;
            end else begin
                visible_next = 1'b0;
                if (in_matched_reg) begin
                    last_seen_next = t;
                    visible_next   = 1'b1;
                    cur            = in_bright_reg;
                end
                if (in_ignore_reg) begin
                    decoding_next   = 1'b0;
                    sync_stamp_next = '0;
                    bit_count_next  = '0;
                    shift_id_next   = '0;
                    sync_armed_next = 1'b0;
                    cand_id_next    = '0;
                    cand_cnt_next   = '0;
                    cand_stamp_next = '0;
                    hs_vld_next     = cur;
                    hs_next         = t;
                    ls_vld_next     = !cur;
                    ls_next         = t;
                end else if (!decoding_reg) begin
                    if (cur) begin
                        if (!prev_bright_reg) begin
                            hs_vld_next     = 1'b1;
                            hs_next         = t;
                            ls_vld_next     = 1'b0;
                            sync_armed_next = 1'b0;
                        end
                        // long steady high run: static marker
                        if ((!conf_vld_reg || conf_id_reg == '0) && prev_bright_reg &&
                            hs_vld_reg && since4(t, hs_reg) > S4_W'(static_lim_reg)) begin
                            conf_vld_next   = 1'b1;
                            conf_id_next    = '0;
                            cand_cnt_next   = '0;
                            cand_id_next    = '0;
                            cand_stamp_next = '0;
                        end
                    end else begin
                        if (prev_bright_reg) begin
                            ls_vld_next     = 1'b1;
                            ls_next         = t;
                            sync_armed_next = arm_now;
                            if (arm_now) begin
                                decoding_next   = 1'b1;
                                sync_stamp_next = t;
                                bit_count_next  = '0;
                                shift_id_next   = '0;
                            end
                        end else if (sync_armed_reg && ls_vld_reg &&
                                     since4(t, ls_reg) > S4_W'(nine_bd_reg)) begin
                            sync_armed_next = 1'b0;
                        end
                        hs_vld_next = 1'b0;
                    end
                end else begin
                    if (el4 >= S4_W'(samp_lim)) begin
                        shift_id_next  = shift_new;
                        bit_count_next = bc_new;
                        if (bc_new >= pbits_reg || bc_new == '0) begin
                            // packet complete
                            if (cand_cnt_reg == '0 || cand_id_reg != shift_new || stale) begin
                                cnt_tmp = 2'd1;
                            end else if (cand_cnt_reg < CAND_MAX) begin
                                cnt_tmp = cand_cnt_reg + 2'd1;
                            end
                            cand_id_next    = (cnt_tmp == 2'd1) ? shift_new : cand_id_reg;
                            cand_stamp_next = t;
                            cand_cnt_next   = cnt_tmp;
                            if (conf_vld_reg && conf_id_reg == shift_new) begin
                                cand_cnt_next = need;
                            end else if (cnt_tmp >= need) begin
                                conf_id_next  = shift_new;
                                conf_vld_next = 1'b1;
                                cand_cnt_next = '0;
                            end
                            decoding_next   = 1'b0;
                            sync_armed_next = 1'b0;
                            hs_vld_next     = cur;
                            hs_next         = t;
                            ls_vld_next     = !cur;
                            ls_next         = t;
                        end
                    end
                    if (el4 > S4_W'(unseen_lim_reg)) begin
                        decoding_next   = 1'b0;
                        sync_armed_next = 1'b0;
                        hs_vld_next     = cur;
                        hs_next         = t;
                        ls_vld_next     = !cur;
                        ls_next         = t;
                    end
                end
                prev_bright_next = cur;
            end
        end
    end

    // result fields
    logic [TIME_W-1:0]   age_us;
    logic                res_seen, res_id_ok, res_report;
    logic [ID_WIDTH-1:0] res_id;
    logic [OUT_W-1:0]    out_data_next;

    assign age_us     = since(t, last_seen_next);
    assign res_seen   = live_item && !retired && visible_next;
    assign res_id_ok  = live_item && conf_vld_next;
    assign res_id     = res_id_ok ? conf_id_next : '0;
    assign res_report = live_item && !retired && conf_vld_next &&
                        ({age_us, 2'b00} < S4_W'(unseen_lim_reg));

    always_comb begin
        out_data_next = '0;
        out_data_next[OUT_USED-1:0] = {(live_item ? age_us : {TIME_W{1'b0}}), res_report,
                                       res_id, res_id_ok, res_seen, retired};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_active_reg <= 1'b0;
            decoding_reg     <= 1'b0;
            sync_stamp_reg   <= '0;
            bit_count_reg    <= '0;
            shift_id_reg     <= '0;
            prev_bright_reg  <= 1'b0;
            hs_vld_reg       <= 1'b0;
            ls_vld_reg       <= 1'b0;
            sync_armed_reg   <= 1'b0;
            conf_vld_reg     <= 1'b0;
            conf_id_reg      <= '0;
            cand_id_reg      <= '0;
            cand_cnt_reg     <= '0;
            cand_stamp_reg   <= '0;
            last_seen_reg    <= '0;
            visible_reg      <= 1'b0;
        end else if (advance) begin
            track_active_reg <= track_active_next;
            decoding_reg     <= decoding_next;
            sync_stamp_reg   <= sync_stamp_next;
            bit_count_reg    <= bit_count_next;
            shift_id_reg     <= shift_id_next;
            prev_bright_reg  <= prev_bright_next;
            hs_vld_reg       <= hs_vld_next;
            ls_vld_reg       <= ls_vld_next;
            sync_armed_reg   <= sync_armed_next;
            conf_vld_reg     <= conf_vld_next;
            conf_id_reg      <= conf_id_next;
            cand_id_reg      <= cand_id_next;
            cand_cnt_reg     <= cand_cnt_next;
            cand_stamp_reg   <= cand_stamp_next;
            last_seen_reg    <= last_seen_next;
            visible_reg      <= visible_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hs_reg       <= hs_next;
            ls_reg       <= ls_next;
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

@@ rtl/bmid_checker.sv @@
`default_nettype none
module bmid_checker #(
    parameter int ID_WIDTH = bmid_pkg::ID_WIDTH_DEF
) (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [((ID_WIDTH + 36 + 7) / 8) * 8-1:0] m_axis_tdata
);

    localparam int RETIRED_B = 0;
    localparam int SEEN_B    = 1;
    localparam int IDOK_B    = 2;
    localparam int REPORT_B  = ID_WIDTH + 3;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // a retiring beat is neither seen nor reported
    a_retire_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[RETIRED_B] |->
            !m_axis_tdata[SEEN_B] && !m_axis_tdata[REPORT_B])
        else $error("retired beat shows visibility or report");

    // no confirmed id: id reads zero and nothing is reported
    a_no_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[IDOK_B] |->
            m_axis_tdata[REPORT_B-1:IDOK_B+1] == '0 && !m_axis_tdata[REPORT_B])
        else $error("id or report without confirmed id");

    // a result beat only follows an accepted input beat
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid ##1 m_axis_tvalid |-> $past(s_axis_tvalid && s_axis_tready, 2) ||
            $past(!s_axis_tready, 1))
        else $error("result beat without an input beat");

endmodule

bind blink_marker_id_decoder bmid_checker #(.ID_WIDTH(ID_WIDTH)) u_bmid_checker (.*);
`default_nettype wire
